/* src/wstd_pkg.sv */
package wstd_pkg;

	localparam int unsigned DEF_NUM_SERVERS  = 16;
	localparam int unsigned DEF_TIME_WIDTH   = 48;
	localparam int unsigned DEF_WEIGHT_WIDTH = 16;

	localparam int unsigned SLOT_W      = 4;
	localparam int unsigned WEIGHT_IN_W = 16;
	localparam int unsigned DUR_W       = 20;
	localparam int unsigned NS_W        = 5;
	localparam int unsigned APB_AW      = 2;
	localparam int unsigned APB_DW      = 32;

	localparam logic [APB_AW-1:0] ADDR_NUM_SERVERS = '0;
	localparam logic [NS_W-1:0]   NUM_SERVERS_RST  = 5'd16;

	localparam logic REQ_LOAD     = 1'b0;
	localparam logic REQ_DISPATCH = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SCAN_A = 6'b000010,
		ST_WAIT_A = 6'b000100,
		ST_SCAN_B = 6'b001000,
		ST_WAIT_B = 6'b010000,
		ST_COMMIT = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;
		logic launch;
		logic issue;
		logic pass_b;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic last_issue;
	} stat_t;

endpackage

/* src/wstd_ram.sv */
module wstd_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/wstd_ctrl.sv */
module wstd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            req_type,
	input  wstd_pkg::stat_t stat,
	output wstd_pkg::cmd_t  cmd,
	output logic            busy
);

	import wstd_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (req_type == REQ_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.launch = 1'b1;
						state_nx   = ST_SCAN_A;
					end
				end
			end
			ST_SCAN_A: begin
				cmd.issue = 1'b1;
				if (stat.last_issue) begin
					state_nx = ST_WAIT_A;
				end
			end
			ST_WAIT_A: begin
				state_nx = ST_SCAN_B;
			end
			ST_SCAN_B: begin
				cmd.issue  = 1'b1;
				cmd.pass_b = 1'b1;
				if (stat.last_issue) begin
					state_nx = ST_WAIT_B;
				end
			end
			ST_WAIT_B: begin
				state_nx = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_nx   = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

/* src/wstd_dp.sv */
module wstd_dp #(
	parameter int unsigned NUM_SERVERS  = wstd_pkg::DEF_NUM_SERVERS,
	parameter int unsigned TIME_WIDTH   = wstd_pkg::DEF_TIME_WIDTH,
	parameter int unsigned WEIGHT_WIDTH = wstd_pkg::DEF_WEIGHT_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  wstd_pkg::cmd_t                   cmd,
	output wstd_pkg::stat_t                  stat,
	input  logic [wstd_pkg::NS_W-1:0]        num_servers,
	input  logic [wstd_pkg::SLOT_W-1:0]      server_slot,
	input  logic [wstd_pkg::WEIGHT_IN_W-1:0] server_weight_in,
	input  logic [wstd_pkg::DUR_W-1:0]       task_duration,
	output logic                             done,
	output logic [wstd_pkg::SLOT_W-1:0]      assigned_server
);

	import wstd_pkg::*;

	localparam int unsigned IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
	localparam int unsigned SUM_W = TIME_WIDTH + 1;
	localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

	logic [NUM_SERVERS-1:0]  bvalid_q;
	logic [NUM_SERVERS-1:0]  wvalid_q;
	logic [TIME_WIDTH-1:0]   cur_q;
	logic [TIME_WIDTH-1:0]   task_q;
	logic [TIME_WIDTH-1:0]   t0_q;
	logic [DUR_W-1:0]        dur_q;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        last_idx;

	logic                    v_s1;
	logic                    pass_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic                    bv_s1;
	logic                    wv_s1;

	logic                    any_free_q;
	logic [TIME_WIDTH-1:0]   earliest_q;
	logic                    found_q;
	logic [IDX_W-1:0]        best_q;
	logic [WEIGHT_WIDTH-1:0] best_w_q;
	logic                    done_q;
	logic [SLOT_W-1:0]       server_q;

	logic [TIME_WIDTH-1:0]   busy_rd;
	logic [WEIGHT_WIDTH-1:0] weight_rd;
	logic [TIME_WIDTH-1:0]   bval;
	logic [WEIGHT_WIDTH-1:0] wval;
	logic [TIME_WIDTH-1:0]   t_eff;
	logic [SUM_W-1:0]        busy_sum;
	logic [SUM_W-1:0]        task_sum;
	logic [TIME_WIDTH-1:0]   busy_new;
	logic [TIME_WIDTH-1:0]   task_new;
	logic                    slot_ok;
	logic [IDX_W-1:0]        slot_idx;
	logic                    free_a;
	logic                    free_b;

	// active server count clamped to 1..NUM_SERVERS, kept as last index
	always_comb begin
		if (num_servers == '0) begin
			last_idx = '0;
		end else if (32'(num_servers) > NUM_SERVERS) begin
			last_idx = IDX_W'(NUM_SERVERS - 1);
		end else begin
			last_idx = IDX_W'(num_servers - 1'b1);
		end
	end

	assign stat.last_issue = (idx_q == last_idx);

	assign slot_ok  = (32'(server_slot) < NUM_SERVERS);
	assign slot_idx = IDX_W'(server_slot);

	// busy entries not written since the last load or reset, and weight entries not written since reset, read as zero
	assign bval  = bv_s1 ? busy_rd : '0;
	assign wval  = wv_s1 ? weight_rd : '0;
	assign t_eff = any_free_q ? t0_q : earliest_q;

	assign free_a = (bval <= t0_q);
	assign free_b = (bval <= t_eff);

	assign busy_sum = {1'b0, t_eff} + SUM_W'(dur_q);
	assign task_sum = {1'b0, task_q} + SUM_W'(1);
	assign busy_new = busy_sum[TIME_WIDTH] ? TIME_MAX : busy_sum[TIME_WIDTH-1:0];
	assign task_new = task_sum[TIME_WIDTH] ? TIME_MAX : task_sum[TIME_WIDTH-1:0];

	wstd_ram #(
		.WIDTH (TIME_WIDTH),
		.DEPTH (NUM_SERVERS)
	) u_busy_ram (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (best_q),
		.wdata (busy_new),
		.re    (cmd.issue),
		.raddr (idx_q),
		.rdata (busy_rd)
	);

	wstd_ram #(
		.WIDTH (WEIGHT_WIDTH),
		.DEPTH (NUM_SERVERS)
	) u_weight_ram (
		.clk   (clk),
		.we    (cmd.load & slot_ok),
		.waddr (slot_idx),
		.wdata (WEIGHT_WIDTH'(server_weight_in)),
		.re    (cmd.issue),
		.raddr (idx_q),
		.rdata (weight_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_q <= '0;
			wvalid_q <= '0;
			cur_q    <= '0;
			task_q   <= '0;
			idx_q    <= '0;
			v_s1     <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			v_s1   <= cmd.issue;
			done_q <= cmd.commit;
			if (cmd.issue) begin
				idx_q <= stat.last_issue ? '0 : idx_q + 1'b1;
			end
			if (cmd.load) begin
				bvalid_q <= '0;
				cur_q    <= '0;
				task_q   <= '0;
				if (slot_ok) begin
					wvalid_q[slot_idx] <= 1'b1;
				end
			end
			if (cmd.commit) begin
				bvalid_q[best_q] <= 1'b1;
				cur_q            <= t_eff;
				task_q           <= task_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.launch) begin
			t0_q  <= (cur_q > task_q) ? cur_q : task_q;
			dur_q <= task_duration;
		end
		if (cmd.issue) begin
			pass_s1 <= cmd.pass_b;
			idx_s1  <= idx_q;
			bv_s1   <= bvalid_q[idx_q];
			wv_s1   <= wvalid_q[idx_q];
		end
		// first pass: any free server, earliest busy-until time
		if (v_s1 && !pass_s1) begin
			if (idx_s1 == '0) begin
				any_free_q <= free_a;
				earliest_q <= bval;
			end else begin
				any_free_q <= any_free_q | free_a;
				if (bval < earliest_q) begin
					earliest_q <= bval;
				end
			end
		end
		// second pass: lowest weight among free servers, lower index wins ties
		if (v_s1 && pass_s1) begin
			if (idx_s1 == '0) begin
				found_q  <= free_b;
				best_q   <= '0;
				best_w_q <= wval;
			end else if (free_b && (!found_q || (wval < best_w_q))) begin
				found_q  <= 1'b1;
				best_q   <= idx_s1;
				best_w_q <= wval;
			end
		end
		if (cmd.commit) begin
			server_q <= SLOT_W'(best_q);
		end
	end

	assign done            = done_q;
	assign assigned_server = server_q;

endmodule

/* src/weighted_server_task_dispatcher_core.sv */
// channel   ports                                              handshake
// -------   -------------------------------------------------  ------------------------------
// request   req_type, server_slot, server_weight_in,           taken when start & !busy
//           task_duration
// result    assigned_server                                    valid for one cycle with done
// config    psel, penable, pwrite, paddr, pwdata, prdata       write on psel & penable & pwrite
//
// a load item completes in the accept cycle and does not raise busy
// a dispatch item keeps busy in scan A, wait A, scan B, wait B, commit; done, registered from
// commit, rises as busy falls. busy-until and weight memories are read one entry per cycle,
// scanned twice: once for the earliest busy-until time, once for the lightest free server
// reset clears all times, the task count and every server entry at once
// the receiver cannot stall: done is a single-cycle strobe
module weighted_server_task_dispatcher_core #(
	parameter int unsigned NUM_SERVERS  = wstd_pkg::DEF_NUM_SERVERS,
	parameter int unsigned TIME_WIDTH   = wstd_pkg::DEF_TIME_WIDTH,
	parameter int unsigned WEIGHT_WIDTH = wstd_pkg::DEF_WEIGHT_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             req_type,
	input  logic [wstd_pkg::SLOT_W-1:0]      server_slot,
	input  logic [wstd_pkg::WEIGHT_IN_W-1:0] server_weight_in,
	input  logic [wstd_pkg::DUR_W-1:0]       task_duration,
	output logic                             done,
	output logic [wstd_pkg::SLOT_W-1:0]      assigned_server,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [wstd_pkg::APB_AW-1:0]      paddr,
	input  logic [wstd_pkg::APB_DW-1:0]      pwdata,
	output logic [wstd_pkg::APB_DW-1:0]      prdata,
	output logic                             pready
);

	import wstd_pkg::*;

	cmd_t            cmd;
	stat_t           stat;
	logic [NS_W-1:0] num_servers_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_servers_q <= NUM_SERVERS_RST;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_NUM_SERVERS)) begin
			num_servers_q <= pwdata[NS_W-1:0];
		end
	end

	assign prdata = (paddr == ADDR_NUM_SERVERS) ? APB_DW'(num_servers_q) : '0;

	wstd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	wstd_dp #(
		.NUM_SERVERS  (NUM_SERVERS),
		.TIME_WIDTH   (TIME_WIDTH),
		.WEIGHT_WIDTH (WEIGHT_WIDTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.num_servers      (num_servers_q),
		.server_slot      (server_slot),
		.server_weight_in (server_weight_in),
		.task_duration    (task_duration),
		.done             (done),
		.assigned_server  (assigned_server)
	);

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
	import wstd_pkg::*;

	localparam int unsigned NSRV = DEF_NUM_SERVERS;
	localparam int unsigned TW   = DEF_TIME_WIDTH;
	localparam int unsigned WW   = DEF_WEIGHT_WIDTH;
	localparam logic [TW-1:0] TIME_SAT = {TW{1'b1}};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic                   req_type = REQ_LOAD;
	logic [SLOT_W-1:0]      server_slot = '0;
	logic [WEIGHT_IN_W-1:0] server_weight_in = '0;
	logic [DUR_W-1:0]       task_duration = '0;
	logic                   done;
	logic [SLOT_W-1:0]      assigned_server;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [APB_AW-1:0]      paddr = '0;
	logic [APB_DW-1:0]      pwdata = '0;
	logic [APB_DW-1:0]      prdata;
	logic                   pready;

	weighted_server_task_dispatcher_core u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.req_type         (req_type),
		.server_slot      (server_slot),
		.server_weight_in (server_weight_in),
		.task_duration    (task_duration),
		.done             (done),
		.assigned_server  (assigned_server),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	// dispatcher shadow state
	logic [WW-1:0]   server_weight [NSRV];
	logic [TW-1:0]   server_free_at [NSRV];
	logic [TW-1:0]   clock_now;
	logic [TW-1:0]   tasks_seen;
	logic [NS_W-1:0] pool_size;

	logic [SLOT_W-1:0] expected_servers[$];
	int errors = 0;
	int items_sent = 0;
	int sender_idle_pct = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int active_servers();
		if (pool_size == 0)
			return 1;
		if (pool_size > NSRV)
			return NSRV;
		return int'(pool_size);
	endfunction

	function automatic logic [TW-1:0] time_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
		logic [TW:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[TW] ? TIME_SAT : sum[TW-1:0];
	endfunction

	function automatic void restart_pool();
		for (int i = 0; i < NSRV; i++)
			server_free_at[i] = '0;
		clock_now = '0;
		tasks_seen = '0;
	endfunction

	// applies one accepted item to the shadow state, queues the expected server for a dispatch
	function automatic void dispatch_request(input logic rt, input logic [SLOT_W-1:0] slot,
			input logic [WEIGHT_IN_W-1:0] w, input logic [DUR_W-1:0] dur);
		int n;
		int best;
		bit found;
		bit any_free;
		logic [TW-1:0] t;
		logic [TW-1:0] earliest;
		if (rt == REQ_LOAD) begin
			if (slot < NSRV)
				server_weight[slot] = w[WW-1:0];
			restart_pool();
			return;
		end
		n = active_servers();
		best = 0;
		found = 0;
		any_free = 0;
		t = (clock_now > tasks_seen) ? clock_now : tasks_seen;
		for (int i = 0; i < n; i++)
			if (server_free_at[i] <= t)
				any_free = 1;
		if (!any_free) begin
			// nobody free: jump ahead to the first server that frees up
			earliest = server_free_at[0];
			for (int i = 1; i < n; i++)
				if (server_free_at[i] < earliest)
					earliest = server_free_at[i];
			t = earliest;
		end
		for (int i = 0; i < n; i++) begin
			if (server_free_at[i] <= t && (!found || server_weight[i] < server_weight[best])) begin
				best = i;
				found = 1;
			end
		end
		clock_now = t;
		server_free_at[best] = time_add(t, TW'(dur));
		tasks_seen = time_add(tasks_seen, TW'(1));
		expected_servers = {expected_servers, best[SLOT_W-1:0]};
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_servers.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none actual %0d", $time,
					assigned_server);
			end else begin
				if (assigned_server !== expected_servers[0]) begin
					errors++;
					$display("%0t: assigned_server mismatch, expected %0d actual %0d", $time,
						expected_servers[0], assigned_server);
				end
				void'(expected_servers.pop_front());
			end
		end
	end

	// drives one item and holds it until taken; start is left high for a back-to-back item
	task automatic send_item(input logic rt, input logic [SLOT_W-1:0] slot,
			input logic [WEIGHT_IN_W-1:0] w, input logic [DUR_W-1:0] dur);
		int gap;
		start <= 1'b1;
		req_type <= rt;
		server_slot <= slot;
		server_weight_in <= w;
		task_duration <= dur;
		do @(posedge clk); while (busy);
		dispatch_request(rt, slot, w, dur);
		items_sent++;
		if ($urandom_range(99) < sender_idle_pct) begin
			gap = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (expected_servers.size() != 0)
			@(posedge clk);
		repeat (2 * NSRV + 8) @(posedge clk);
	endtask

	task automatic write_pool_size(input logic [NS_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_NUM_SERVERS;
		pwdata <= {(APB_DW-NS_W)'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pool_size = val;
		// read it back
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[NS_W-1:0] !== pool_size) begin
			errors++;
			$display("%0t: num_servers readback mismatch, expected %0d actual %0d", $time,
				pool_size, prdata[NS_W-1:0]);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [WEIGHT_IN_W-1:0] pick_weight();
		case ($urandom_range(3))
			0: return WEIGHT_IN_W'($urandom_range(3));
			1: return ($urandom_range(1) != 0) ? '1 : '0;
			2: return WEIGHT_IN_W'($urandom_range(65535, 65530));
			default: return WEIGHT_IN_W'($urandom);
		endcase
	endfunction

	function automatic logic [DUR_W-1:0] pick_duration();
		int n;
		n = active_servers();
		case ($urandom_range(9))
			0: return '0;
			1, 2, 3, 4: return DUR_W'($urandom_range(2 * n + 2));
			5, 6: return DUR_W'($urandom_range(8 * n));
			7: return '1;
			default: return DUR_W'($urandom);
		endcase
	endfunction

	task automatic send_random_item();
		send_item(logic'($urandom_range(1)), SLOT_W'($urandom), WEIGHT_IN_W'($urandom),
			DUR_W'($urandom));
	endtask

	// a few weight loads to restart the run, then a burst of tasks, with some noise mixed in
	task automatic run_sequence();
		int loads;
		int tasks;
		logic [SLOT_W-1:0] slot;
		loads = $urandom_range(0, 4);
		tasks = $urandom_range(3, 30);
		for (int i = 0; i < loads; i++) begin
			slot = ($urandom_range(3) != 0) ? SLOT_W'($urandom_range(active_servers() - 1))
				: SLOT_W'($urandom);
			send_item(REQ_LOAD, slot, pick_weight(), DUR_W'($urandom));
		end
		for (int i = 0; i < tasks; i++) begin
			if ($urandom_range(9) == 0)
				send_random_item();
			else
				send_item(REQ_DISPATCH, SLOT_W'($urandom), WEIGHT_IN_W'($urandom),
					pick_duration());
		end
	endtask

	task automatic test_directed_dispatch();
		// default pool of 16, all weights zero: ties go to the lowest index
		send_item(REQ_DISPATCH, '1, '1, '0);
		send_item(REQ_DISPATCH, '0, '0, '1);
		send_item(REQ_DISPATCH, '1, '0, '0);
		send_item(REQ_DISPATCH, '0, '1, 20'd3);
		// restart with new weights, two of them equal, ignored duration at its extreme
		send_item(REQ_LOAD, 4'd0, '1, '1);
		send_item(REQ_LOAD, 4'd1, 16'd5, '0);
		send_item(REQ_LOAD, 4'd15, '0, 20'hAAAAA);
		send_item(REQ_LOAD, 4'd2, 16'd5, 20'h55555);
		send_item(REQ_DISPATCH, '0, '0, 20'd100);
		send_item(REQ_DISPATCH, '0, '0, 20'd100);
		send_item(REQ_DISPATCH, '1, '1, '1);
		send_item(REQ_DISPATCH, '0, '0, 20'd1);
		send_item(REQ_DISPATCH, '0, '0, 20'd0);
		wait_idle();
		// single server: every task after the first waits for the time jump
		write_pool_size(5'd1);
		send_item(REQ_LOAD, 4'd0, 16'd7, '0);
		send_item(REQ_DISPATCH, '0, '0, 20'd100);
		send_item(REQ_DISPATCH, '0, '0, 20'd50);
		send_item(REQ_DISPATCH, '0, '0, '1);
		send_item(REQ_DISPATCH, '0, '0, '0);
		wait_idle();
		// pool of two, equal weights, both busy at once
		write_pool_size(5'd2);
		send_item(REQ_LOAD, 4'd1, 16'd7, '0);
		send_item(REQ_DISPATCH, '0, '0, 20'd10);
		send_item(REQ_DISPATCH, '0, '0, 20'd10);
		send_item(REQ_DISPATCH, '0, '0, 20'd10);
		send_item(REQ_DISPATCH, '0, '0, 20'd10);
		wait_idle();
	endtask

	task automatic test_pool_size_extremes();
		logic [NS_W-1:0] sizes[6] = '{5'd0, 5'd31, 5'd17, 5'd1, 5'd3, 5'd16};
		foreach (sizes[k]) begin
			wait_idle();
			write_pool_size(sizes[k]);
			run_sequence();
			run_sequence();
		end
		wait_idle();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int target);
		int stop_at;
		sender_idle_pct = idle_pct;
		stop_at = items_sent + target;
		while (items_sent < stop_at) begin
			if ($urandom_range(4) == 0) begin
				wait_idle();
				case ($urandom_range(3))
					0: write_pool_size(NS_W'($urandom_range(1, 4)));
					1: write_pool_size(NS_W'($urandom_range(5, 16)));
					2: write_pool_size(NS_W'($urandom));
					default: write_pool_size(($urandom_range(1) != 0) ? 5'd0 : 5'd31);
				endcase
			end
			run_sequence();
		end
		wait_idle();
	endtask

	initial begin
		for (int i = 0; i < NSRV; i++)
			server_weight[i] = '0;
		restart_pool();
		pool_size = NUM_SERVERS_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_dispatch();
		test_pool_size_extremes();
		test_random_traffic(34, 430);
		test_random_traffic(64, 430);
		test_random_traffic(0, 430);

		while (expected_servers.size() != 0)
			@(posedge clk);
		repeat (2 * NSRV + 10) @(posedge clk);
		if (errors == 0 && expected_servers.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
